/* hw/rtl/bbt_pkg.sv */
package bbt_pkg;

    // number of axes of a point and of the rotation
    localparam int unsigned Axes = 3;

    // fraction bits of a rotation coefficient
    localparam int unsigned CoefFrac = 14;

    localparam int unsigned CoordW = 32;
    localparam int unsigned CoefW  = 16;
    localparam int unsigned RowW   = 3 * CoefW;
    localparam int unsigned ProdW  = CoordW + CoefW;
    localparam int unsigned TermW  = ProdW - CoefFrac;
    // translation plus three terms, grown by two bits
    localparam int unsigned SumW   = TermW + 2;

    // configuration register indexes
    localparam logic [2:0] RegRotRowX = 3'd0;
    localparam logic [2:0] RegRotRowY = 3'd1;
    localparam logic [2:0] RegRotRowZ = 3'd2;
    localparam logic [2:0] RegShiftX  = 3'd3;
    localparam logic [2:0] RegShiftY  = 3'd4;
    localparam logic [2:0] RegShiftZ  = 3'd5;

    // reset values give the identity transform
    localparam logic [RowW-1:0] RotRowXRst = 48'h4000_0000_0000;
    localparam logic [RowW-1:0] RotRowYRst = 48'h0000_4000_0000;
    localparam logic [RowW-1:0] RotRowZRst = 48'h0000_0000_4000;

    localparam logic signed [SumW-1:0] SatMax = 36'sd2147483647;
    localparam logic signed [SumW-1:0] SatMin = -36'sd2147483648;

    typedef logic signed [CoordW-1:0] t_coord;
    typedef logic signed [CoefW-1:0]  t_coef;
    typedef logic        [RowW-1:0]   t_row;
    typedef logic signed [ProdW-1:0]  t_prod;
    typedef logic signed [TermW-1:0]  t_term;
    typedef logic signed [SumW-1:0]   t_sum;

endpackage

/* hw/rtl/box_bounds_transform.sv */
// Axis-aligned box transform into the global frame.
//
// Input channel (i_in_valid / o_in_ready) carries one local box word: the
// minimum and maximum corners. Output channel (o_out_valid / i_out_ready)
// returns the global box that encloses all eight corners after R * p + t.
// Configuration channel (i_cfg_valid / o_cfg_ready, always ready) writes the
// three packed rotation rows and the translation by register index; the user
// must write it only while no box is in flight, as the block does not enforce it.
//
// There are 3 register stages: products, per-axis min/max of each corner
// pair, then sum with translation and saturation. Throughput is one box per
// cycle while the receiver takes words; every stage takes a new word each
// cycle while the stage after it moves on.
// Reset clears the stage valid bits and loads the identity transform.
// When the receiver stalls, the result holds in the output register and
// earlier stages keep filling bubbles; o_in_ready drops once all three
// stages hold words.
module box_bounds_transform
    import bbt_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  t_coord        i_lo_x,
    input  t_coord        i_lo_y,
    input  t_coord        i_lo_z,
    input  t_coord        i_hi_x,
    input  t_coord        i_hi_y,
    input  t_coord        i_hi_z,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output t_coord        o_out_lo_x,
    output t_coord        o_out_lo_y,
    output t_coord        o_out_lo_z,
    output t_coord        o_out_hi_x,
    output t_coord        o_out_hi_y,
    output t_coord        o_out_hi_z,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [RowW-1:0] i_cfg_data
);

    // configuration registers
    t_row   r_rot   [Axes];
    t_coord r_shift [Axes];

    // stage valid bits and advance enables
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    // stage 1: shifted products, [row][column]
    t_term r_plo [Axes][Axes];
    t_term r_phi [Axes][Axes];
    t_term n_plo [Axes][Axes];
    t_term n_phi [Axes][Axes];

    // stage 2: smaller and larger term of each corner pair
    t_term r_mn [Axes][Axes];
    t_term r_mx [Axes][Axes];
    t_term n_mn [Axes][Axes];
    t_term n_mx [Axes][Axes];

    // stage 3: saturated bounds
    t_coord r_lo [Axes];
    t_coord r_hi [Axes];
    t_coord n_lo [Axes];
    t_coord n_hi [Axes];

    t_coord in_lo [Axes];
    t_coord in_hi [Axes];

    assign in_lo[0] = i_lo_x;
    assign in_lo[1] = i_lo_y;
    assign in_lo[2] = i_lo_z;
    assign in_hi[0] = i_hi_x;
    assign in_hi[1] = i_hi_y;
    assign in_hi[2] = i_hi_z;

    // a stage moves on when it is empty or the next one moves on
    assign en3 = !r_v3 || i_out_ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    assign o_in_ready  = en1;
    assign o_cfg_ready = 1'b1;

    // configuration writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot[0]   <= RotRowXRst;
            r_rot[1]   <= RotRowYRst;
            r_rot[2]   <= RotRowZRst;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                RegRotRowX: r_rot[0]   <= i_cfg_data;
                RegRotRowY: r_rot[1]   <= i_cfg_data;
                RegRotRowZ: r_rot[2]   <= i_cfg_data;
                RegShiftX:  r_shift[0] <= i_cfg_data[CoordW-1:0];
                RegShiftY:  r_shift[1] <= i_cfg_data[CoordW-1:0];
                RegShiftZ:  r_shift[2] <= i_cfg_data[CoordW-1:0];
                default: ;
            endcase
        end
    end

    // stage 1: coefficient times lo and hi, floor shift by the fraction
    always_comb begin
        t_coef c;
        t_prod plo;
        t_prod phi;
        for (int a = 0; a < Axes; a++) begin
            for (int k = 0; k < Axes; k++) begin
                c   = t_coef'(r_rot[a][RowW-1-CoefW*k -: CoefW]);
                plo = t_prod'(c) * t_prod'(in_lo[k]);
                phi = t_prod'(c) * t_prod'(in_hi[k]);
                n_plo[a][k] = t_term'(plo >>> CoefFrac);
                n_phi[a][k] = t_term'(phi >>> CoefFrac);
            end
        end
    end

    // stage 2: each term is chosen independently per column
    always_comb begin
        for (int a = 0; a < Axes; a++) begin
            for (int k = 0; k < Axes; k++) begin
                if (r_plo[a][k] < r_phi[a][k]) begin
                    n_mn[a][k] = r_plo[a][k];
                    n_mx[a][k] = r_phi[a][k];
                end else begin
                    n_mn[a][k] = r_phi[a][k];
                    n_mx[a][k] = r_plo[a][k];
                end
            end
        end
    end

    // stage 3: translation plus terms; saturation is monotone, so the
    // bound of the clamped corners is the clamp of the bound
    always_comb begin
        t_sum smn;
        t_sum smx;
        for (int a = 0; a < Axes; a++) begin
            smn = t_sum'(r_shift[a]) + t_sum'(r_mn[a][0])
                + t_sum'(r_mn[a][1]) + t_sum'(r_mn[a][2]);
            smx = t_sum'(r_shift[a]) + t_sum'(r_mx[a][0])
                + t_sum'(r_mx[a][1]) + t_sum'(r_mx[a][2]);
            if (smn > SatMax) begin
                n_lo[a] = t_coord'(SatMax);
            end else if (smn < SatMin) begin
                n_lo[a] = t_coord'(SatMin);
            end else begin
                n_lo[a] = t_coord'(smn);
            end
            if (smx > SatMax) begin
                n_hi[a] = t_coord'(SatMax);
            end else if (smx < SatMin) begin
                n_hi[a] = t_coord'(SatMin);
            end else begin
                n_hi[a] = t_coord'(smx);
            end
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_in_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // data registers
    always_ff @(posedge i_clk) begin
        if (en1 && i_in_valid) begin
            r_plo <= n_plo;
            r_phi <= n_phi;
        end
        if (en2 && r_v1) begin
            r_mn <= n_mn;
            r_mx <= n_mx;
        end
        if (en3 && r_v2) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_lo_x  = r_lo[0];
    assign o_out_lo_y  = r_lo[1];
    assign o_out_lo_z  = r_lo[2];
    assign o_out_hi_x  = r_hi[0];
    assign o_out_hi_y  = r_hi[1];
    assign o_out_hi_z  = r_hi[2];

endmodule

/* hw/rtl/bbt_checker.sv */
module bbt_checker
    import bbt_pkg::*;
(
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input t_coord        o_out_lo_x,
    input t_coord        o_out_lo_y,
    input t_coord        o_out_lo_z,
    input t_coord        o_out_hi_x,
    input t_coord        o_out_hi_y,
    input t_coord        o_out_hi_z
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid
            && $stable(o_out_lo_x) && $stable(o_out_lo_y) && $stable(o_out_lo_z)
            && $stable(o_out_hi_x) && $stable(o_out_hi_y) && $stable(o_out_hi_z))
        else $error("stalled output word changed");

    // the global box is never inverted
    a_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_lo_x <= o_out_hi_x && o_out_lo_y <= o_out_hi_y
            && o_out_lo_z <= o_out_hi_z)
        else $error("output box inverted");

    // input back-pressure only when a result waits at the output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with empty output");

    // with the receiver taking words, an accepted box passes through the stage registers to the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("accepted box not delivered after three cycles");

    // nothing is shown straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind box_bounds_transform bbt_checker u_bbt_checker (.*);
